>>> hw/rtl/gnsd_pkg.sv
// shared types and constants for the gauge needle slew drive
package gnsd_pkg;

    // command codes carried in s_tuser
    localparam logic CMD_TARGET = 1'b0;
    localparam logic CMD_TICK   = 1'b1;

    // configuration register indexes
    localparam int unsigned CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_CHANGE_RATE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RETURN_RATE    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_REST_ANGLE     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_UPPER_LIMIT    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LOWER_LIMIT    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_RESETS  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_MOTION_ENABLED = 3'd6;

    localparam int unsigned ANGLE_W = 16;
    localparam int unsigned TIME_W  = 16;
    localparam int unsigned RATE_W  = 17;

    // configuration register set
    typedef struct packed {
        logic        [15:0] change_rate;
        logic        [15:0] return_rate;
        logic signed [15:0] rest_angle;
        logic signed [15:0] upper_limit;
        logic signed [15:0] lower_limit;
        logic               target_resets;
        logic               motion_enabled;
    } gnsd_cfg_t;

    // needle state carried from item to item
    typedef struct packed {
        logic signed [ANGLE_W-1:0] position;
        logic signed [ANGLE_W-1:0] target;
        logic signed [RATE_W-1:0]  rate;
        logic                      returning;
    } gnsd_state_t;

endpackage

>>> hw/rtl/gauge_needle_slew_drive.sv
// gauge needle slew drive top level: registers, handshakes, result stage
//
//   channel   dir  handshake                 payload
//   s_        in   s_tvalid / s_tready       s_tuser command, s_tdata angle, elapsed_time
//   m_        out  m_tvalid / m_tready       m_tdata shown_angle, needle_angle
//   cfg_      in   cfg_valid / cfg_ready     cfg_index register, cfg_data value
//
// one request per cycle while the result stage keeps up; a tick passes the
// input register and then the result register, a target request gives none.
// the multiply-add-snap-clamp step lies between the two. aresetn is
// synchronous, active low, and restores register defaults and a resting needle.
// a waiting result stalls the input only when the next request is a tick.
module gauge_needle_slew_drive (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // angle [15:0], elapsed_time [31:16]
    input  logic        s_tuser,   // command
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // shown_angle [15:0], needle_angle [31:16]
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [gnsd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [15:0] cfg_data
);
    import gnsd_pkg::*;

    gnsd_cfg_t          cfg_reg;
    gnsd_state_t        st_reg;
    gnsd_state_t        st_next;
    logic               in_vld_reg;
    logic               in_cmd_reg;
    logic signed [15:0] in_angle_reg;
    logic        [15:0] in_time_reg;
    logic               out_vld_reg;
    logic        [15:0] out_shown_reg;
    logic signed [15:0] out_needle_reg;
    logic        [15:0] shown_angle;
    logic signed [15:0] needle_angle;
    logic               out_free;
    logic               advance;

    // configuration writes
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.change_rate    <= '0;
            cfg_reg.return_rate    <= '0;
            cfg_reg.rest_angle     <= '0;
            cfg_reg.upper_limit    <= 16'sh7fff;
            cfg_reg.lower_limit    <= 16'sh8000;
            cfg_reg.target_resets  <= 1'b0;
            cfg_reg.motion_enabled <= 1'b1;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_CHANGE_RATE:    cfg_reg.change_rate    <= cfg_data;
                REG_RETURN_RATE:    cfg_reg.return_rate    <= cfg_data;
                REG_REST_ANGLE:     cfg_reg.rest_angle     <= cfg_data;
                REG_UPPER_LIMIT:    cfg_reg.upper_limit    <= cfg_data;
                REG_LOWER_LIMIT:    cfg_reg.lower_limit    <= cfg_data;
                REG_TARGET_RESETS:  cfg_reg.target_resets  <= cfg_data[0];
                REG_MOTION_ENABLED: cfg_reg.motion_enabled <= cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    // handshake: a tick moves on only when the result stage can take it
    assign out_free = !out_vld_reg || m_tready;
    assign advance  = in_vld_reg && (in_cmd_reg == CMD_TARGET || out_free);
    assign s_tready = !in_vld_reg || advance;

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_tready) begin
            in_vld_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_cmd_reg   <= s_tuser;
            in_angle_reg <= s_tdata[15:0];
            in_time_reg  <= s_tdata[31:16];
        end
    end

    // needle update
    gnsd_step u_step (
        .cfg          (cfg_reg),
        .st           (st_reg),
        .command      (in_cmd_reg),
        .angle        (in_angle_reg),
        .elapsed_time (in_time_reg),
        .st_next      (st_next),
        .shown_angle  (shown_angle),
        .needle_angle (needle_angle)
    );

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= '0;
        end else if (advance) begin
            st_reg <= st_next;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (advance && in_cmd_reg == CMD_TICK) begin
            out_vld_reg <= 1'b1;
        end else if (m_tready) begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && in_cmd_reg == CMD_TICK) begin
            out_shown_reg  <= shown_angle;
            out_needle_reg <= needle_angle;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {out_needle_reg, out_shown_reg};

    // checks
    a_tick_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && in_cmd_reg == CMD_TICK |=> out_vld_reg)
        else $error("tick did not load the result stage");

    a_stall_only_on_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        in_vld_reg && !advance |-> in_cmd_reg == CMD_TICK && out_vld_reg && !m_tready)
        else $error("input held without a busy result stage");

    a_tick_marks_return: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && in_cmd_reg == CMD_TICK |=> st_reg.returning)
        else $error("return mark not set after tick");

    a_target_clears_return: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && in_cmd_reg == CMD_TARGET |=> !st_reg.returning)
        else $error("return mark not cleared by target request");

    a_needle_in_limits: assert property (@(posedge aclk) disable iff (!aresetn)
        out_vld_reg && cfg_reg.lower_limit <= cfg_reg.upper_limit
        |-> out_needle_reg >= cfg_reg.lower_limit && out_needle_reg <= cfg_reg.upper_limit)
        else $error("needle angle outside limits");

endmodule

>>> hw/rtl/gnsd_step.sv
// one needle update: rate select, slew move, snap to target, clamp
module gnsd_step (
    input  gnsd_pkg::gnsd_cfg_t          cfg,
    input  gnsd_pkg::gnsd_state_t        st,
    input  logic                         command,
    input  logic signed [15:0]           angle,
    input  logic        [15:0]           elapsed_time,
    output gnsd_pkg::gnsd_state_t        st_next,
    output logic        [15:0]           shown_angle,
    output logic signed [15:0]           needle_angle
);
    import gnsd_pkg::*;

    logic signed [RATE_W-1:0]  chg_rate;
    logic signed [RATE_W-1:0]  ret_rate;
    logic signed [RATE_W-1:0]  rate_eff;
    logic signed [32:0]        prod;
    logic signed [32:0]        prod_adj;
    logic signed [RATE_W-1:0]  step;
    logic signed [17:0]        old_x;
    logic signed [17:0]        tgt_x;
    logic signed [17:0]        moved;
    logic signed [17:0]        snapped;
    logic signed [17:0]        pos_mv;
    logic signed [ANGLE_W-1:0] pos_new;

    assign chg_rate = signed'({1'b0, cfg.change_rate});
    assign ret_rate = signed'({1'b0, cfg.return_rate});

    // returning needle heads for rest at the return rate
    always_comb begin
        rate_eff = st.rate;
        if (st.returning) begin
            if (st.position > cfg.rest_angle) begin
                rate_eff = -ret_rate;
            end else if (st.position < cfg.rest_angle) begin
                rate_eff = ret_rate;
            end else begin
                rate_eff = '0;
            end
        end
    end

    // move = rate * dt / 65536, truncated toward zero
    assign prod     = 33'(rate_eff) * signed'({17'b0, elapsed_time});
    assign prod_adj = prod + (prod[32] ? 33'sd65535 : 33'sd0);
    assign step     = prod_adj[32:16];

    assign old_x = 18'(st.position);
    assign tgt_x = 18'(st.target);
    assign moved = old_x + 18'(step);

    // snap to target when the move reaches or crosses it
    always_comb begin
        snapped = moved;
        if (!rate_eff[RATE_W-1] && moved >= tgt_x && old_x <= tgt_x) begin
            snapped = tgt_x;
        end else if (rate_eff[RATE_W-1] && moved <= tgt_x && old_x >= tgt_x) begin
            snapped = tgt_x;
        end
    end

    assign pos_mv = cfg.motion_enabled ? snapped : old_x;

    // clamp, upper limit tested first
    always_comb begin
        if (pos_mv > 18'(cfg.upper_limit)) begin
            pos_new = cfg.upper_limit;
        end else if (pos_mv < 18'(cfg.lower_limit)) begin
            pos_new = cfg.lower_limit;
        end else begin
            pos_new = pos_mv[15:0];
        end
    end

    // next state for either command
    always_comb begin
        st_next = st;
        unique case (command)
            CMD_TARGET: begin
                st_next.target    = angle;
                st_next.rate      = (st.position < angle) ? chg_rate : -chg_rate;
                st_next.returning = 1'b0;
            end
            CMD_TICK: begin
                st_next.position  = pos_new;
                st_next.rate      = rate_eff;
                st_next.returning = 1'b1;
                if (cfg.target_resets) begin
                    st_next.target = cfg.rest_angle;
                end
            end
            default: begin
                st_next = st;
            end
        endcase
    end

    assign shown_angle  = 16'(pos_new + angle);
    assign needle_angle = pos_new;

endmodule

>>> test/tb.sv
// self-checking testbench for the gauge needle slew drive: predictor, scoreboard, stimulus
module tb;
    import gnsd_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 60;
    localparam int DRAIN_CYCLES = 6;
    localparam int RANDOM_PHASES = 9;
    localparam int PHASE_ITEMS = 205;
    // index past the last register, must be ignored
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;

    typedef struct {
        logic [15:0]        shown;
        logic signed [15:0] needle;
    } needle_result_t;

    // needle predictor and queue of expected results
    class needle_scoreboard;
        gnsd_cfg_t                 cfg;
        logic signed [ANGLE_W-1:0] position;
        logic signed [ANGLE_W-1:0] target;
        logic signed [RATE_W-1:0]  rate;
        logic                      returning;
        needle_result_t            expected_q[$];
        int                        checked;
        int                        errors;

        function new();
            cfg.change_rate    = '0;
            cfg.return_rate    = '0;
            cfg.rest_angle     = '0;
            cfg.upper_limit    = 16'h7FFF;
            cfg.lower_limit    = 16'h8000;
            cfg.target_resets  = 1'b0;
            cfg.motion_enabled = 1'b1;
            position  = '0;
            target    = '0;
            rate      = '0;
            returning = 1'b0;
            checked   = 0;
            errors    = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] data);
            case (idx)
                REG_CHANGE_RATE:    cfg.change_rate    = data;
                REG_RETURN_RATE:    cfg.return_rate    = data;
                REG_REST_ANGLE:     cfg.rest_angle     = data;
                REG_UPPER_LIMIT:    cfg.upper_limit    = data;
                REG_LOWER_LIMIT:    cfg.lower_limit    = data;
                REG_TARGET_RESETS:  cfg.target_resets  = data[0];
                REG_MOTION_ENABLED: cfg.motion_enabled = data[0];
                default: ;
            endcase
        endfunction

        function void note_request(logic cmd, logic signed [15:0] ang, logic [15:0] dt);
            longint         old_pos;
            longint         new_pos;
            longint         prod;
            longint         step;
            longint         tgt;
            longint         rest;
            logic           neg;
            needle_result_t res;
            // target request: new aim, speed toward it, no result
            if (cmd == CMD_TARGET) begin
                target = ang;
                rate = (position < ang) ? $signed({1'b0, cfg.change_rate})
                                        : -$signed({1'b0, cfg.change_rate});
                returning = 1'b0;
                return;
            end
            // return mark picks the speed toward rest
            rest = longint'($signed(cfg.rest_angle));
            if (returning) begin
                if (longint'(position) > rest)
                    rate = -$signed({1'b0, cfg.return_rate});
                else if (longint'(position) < rest)
                    rate = $signed({1'b0, cfg.return_rate});
                else
                    rate = '0;
            end
            old_pos = longint'(position);
            new_pos = old_pos;
            // move by rate times time, truncated toward zero, snap on reaching target
            if (cfg.motion_enabled) begin
                prod = longint'(rate) * longint'({1'b0, dt});
                step = ((prod < 0) ? -prod : prod) / 65536;
                if (prod < 0)
                    step = -step;
                new_pos = old_pos + step;
                neg = (rate < 0);
                tgt = longint'(target);
                if (!neg && new_pos >= tgt && old_pos <= tgt)
                    new_pos = tgt;
                else if (neg && new_pos <= tgt && old_pos >= tgt)
                    new_pos = tgt;
            end
            // clamp, upper test first
            if (new_pos > longint'($signed(cfg.upper_limit)))
                new_pos = longint'($signed(cfg.upper_limit));
            else if (new_pos < longint'($signed(cfg.lower_limit)))
                new_pos = longint'($signed(cfg.lower_limit));
            position = new_pos[15:0];
            res.shown  = 16'(position + ang);
            res.needle = position;
            expected_q.push_back(res);
            returning = 1'b1;
            if (cfg.target_resets)
                target = cfg.rest_angle;
        endfunction

        function void check_result(logic [15:0] shown, logic [15:0] needle);
            needle_result_t want;
            if (expected_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected result shown %h needle %h", $time, shown, needle);
                return;
            end
            want = expected_q.pop_front();
            checked++;
            if (shown !== want.shown) begin
                errors++;
                $display("%0t: shown_angle expected %h actual %h", $time, want.shown, shown);
            end
            if (needle !== want.needle) begin
                errors++;
                $display("%0t: needle_angle expected %h actual %h",
                         $time, want.needle, needle);
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [31:0]          s_tdata;   // angle [15:0], elapsed_time [31:16]
    logic                 s_tuser;   // command
    logic                 m_tvalid;
    logic                 m_tready;
    logic [31:0]          m_tdata;   // shown_angle [15:0], needle_angle [31:16]
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [15:0]          cfg_data;

    needle_scoreboard sb = new();
    int  cycle_count;
    int  tick_count;
    int  target_count;
    int  setting_count;
    int  gap_odds;
    int  stall_odds;
    bit  quiet_run;
    bit  hold_off_req;

    gauge_needle_slew_drive dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // clock
    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // watchdog
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d results outstanding", cycle_count, sb.pending());
        $display("gauge_needle_slew_drive test failed");
        $finish;
    end

    // result side: check each accepted result, stall at random or on a hold-off
    initial begin
        m_tready <= 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            @(posedge aclk);
            if (m_tvalid && m_tready)
                sb.check_result(m_tdata[15:0], m_tdata[31:16]);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                m_tready <= 1'b1;
            end else if (!quiet_run && $urandom_range(0, stall_odds) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 3)) @(posedge aclk);
                m_tready <= 1'b1;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    function automatic gnsd_cfg_t make_setting(logic [15:0] cr, logic [15:0] rr,
                                               logic [15:0] rest, logic [15:0] up,
                                               logic [15:0] lo, logic tr, logic me);
        gnsd_cfg_t c;
        c.change_rate    = cr;
        c.return_rate    = rr;
        c.rest_angle     = rest;
        c.upper_limit    = up;
        c.lower_limit    = lo;
        c.target_resets  = tr;
        c.motion_enabled = me;
        return c;
    endfunction

    function automatic logic [15:0] pick_rate();
        case ($urandom_range(0, 7))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2: return 16'($urandom_range(1, 255));
            3, 4: return 16'($urandom_range(256, 8191));
            default: return 16'($urandom());
        endcase
    endfunction

    function automatic logic signed [15:0] pick_angle();
        case ($urandom_range(0, 7))
            0: return 16'h7FFF;
            1: return 16'h8000;
            default: return 16'($urandom());
        endcase
    endfunction

    function automatic logic [15:0] pick_time();
        case ($urandom_range(0, 7))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2, 3, 4: return 16'($urandom_range(1, 2047));
            default: return 16'($urandom());
        endcase
    endfunction

    // mostly ordered limits, sometimes full range, sometimes inverted
    function automatic gnsd_cfg_t random_setting();
        logic [15:0] lo;
        logic [15:0] hi;
        logic [15:0] swap;
        lo = 16'(-int'($urandom_range(0, 32768)));
        hi = 16'($urandom_range(0, 32767));
        case ($urandom_range(0, 7))
            0: begin
                lo = 16'h8000;
                hi = 16'h7FFF;
            end
            1: begin
                swap = lo;
                lo = hi;
                hi = swap;
            end
            default: ;
        endcase
        return make_setting(pick_rate(), pick_rate(), pick_angle(), hi, lo,
                            ($urandom_range(0, 1) == 1), ($urandom_range(0, 5) != 0));
    endfunction

    // one register write request, valid left high for the caller
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        sb.write_reg(idx, data);
    endtask

    task automatic apply_setting(gnsd_cfg_t c);
        write_reg(REG_CHANGE_RATE, c.change_rate);
        write_reg(REG_RETURN_RATE, c.return_rate);
        write_reg(REG_REST_ANGLE, c.rest_angle);
        write_reg(REG_UPPER_LIMIT, c.upper_limit);
        write_reg(REG_LOWER_LIMIT, c.lower_limit);
        write_reg(REG_TARGET_RESETS, {15'($urandom()), c.target_resets});
        write_reg(REG_MOTION_ENABLED, {15'($urandom()), c.motion_enabled});
        write_reg(REG_SPARE, 16'($urandom()));
        cfg_valid <= 1'b0;
        setting_count++;
    endtask

    // one input request, with an optional idle burst ahead of it
    task automatic send_request(logic cmd, logic signed [15:0] ang, logic [15:0] dt);
        if (!quiet_run && $urandom_range(0, gap_odds) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {dt, ang};
        do @(posedge aclk); while (!s_tready);
        sb.note_request(cmd, ang, dt);
        if (cmd == CMD_TICK)
            tick_count++;
        else
            target_count++;
    endtask

    // mostly a target followed by a few ticks, the rest single random requests
    task automatic run_random(int n);
        int sent;
        int burst;
        sent = 0;
        while (sent < n) begin
            if ($urandom_range(0, 3) != 0) begin
                send_request(CMD_TARGET, pick_angle(), 16'($urandom()));
                burst = $urandom_range(1, 6);
                repeat (burst) send_request(CMD_TICK, pick_angle(), pick_time());
                sent += burst + 1;
            end else begin
                send_request(($urandom_range(0, 1) != 0) ? CMD_TICK : CMD_TARGET,
                             pick_angle(), pick_time());
                sent++;
            end
        end
    endtask

    // all results in, then let any trailing target request settle
    task automatic drain();
        while (sb.pending() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // main sequence
    initial begin
        gnsd_cfg_t setting;
        aresetn      <= 1'b0;
        s_tvalid     <= 1'b0;
        s_tuser      <= CMD_TARGET;
        s_tdata      <= '0;
        cfg_valid    <= 1'b0;
        cfg_index    <= REG_CHANGE_RATE;
        cfg_data     <= '0;
        tick_count    = 0;
        target_count  = 0;
        setting_count = 0;
        gap_odds      = 3;
        stall_odds    = 3;
        quiet_run     = 1'b0;
        hold_off_req  = 1'b0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // full speed, full range: extreme targets, offsets and times
        apply_setting(make_setting(16'hFFFF, 16'h8000, 16'h0000, 16'h7FFF, 16'h8000,
                                   1'b0, 1'b1));
        send_request(CMD_TARGET, 16'h7FFF, 16'h0000);
        send_request(CMD_TICK, 16'h8000, 16'hFFFF);
        send_request(CMD_TICK, 16'h7FFF, 16'h0000);
        send_request(CMD_TICK, 16'h0000, 16'hFFFF);
        send_request(CMD_TARGET, 16'h8000, 16'hFFFF);
        send_request(CMD_TICK, 16'h0000, 16'h0001);
        send_request(CMD_TICK, 16'h5555, 16'hFFFF);
        // target equal to the needle angle
        send_request(CMD_TARGET, sb.position, 16'hAAAA);
        send_request(CMD_TICK, 16'h0000, 16'hFFFF);
        s_tvalid <= 1'b0;
        drain();

        // zero rates, inverted limits, target reset to rest
        apply_setting(make_setting(16'h0000, 16'h0000, 16'h8000, -16'sd100, 16'sd100,
                                   1'b1, 1'b1));
        send_request(CMD_TICK, 16'h0000, 16'hFFFF);
        send_request(CMD_TARGET, 16'sd500, 16'h0000);
        send_request(CMD_TICK, 16'h0001, 16'hFFFF);
        send_request(CMD_TICK, 16'hFFFF, 16'h1234);
        send_request(CMD_TARGET, 16'h8000, 16'h0000);
        send_request(CMD_TICK, 16'h7FFF, 16'hFFFF);
        s_tvalid <= 1'b0;
        drain();

        // motion off: clamp, output and target reset still apply
        apply_setting(make_setting(16'd1000, 16'd1000, 16'h7FFF, 16'h7FFF, 16'h8000,
                                   1'b1, 1'b0));
        send_request(CMD_TARGET, 16'sd1000, 16'h0000);
        send_request(CMD_TICK, 16'sd100, 16'hFFFF);
        send_request(CMD_TICK, 16'hFFFF, 16'hFFFF);
        s_tvalid <= 1'b0;

        // random phases, the first two at the register extremes, the last without idling
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            drain();
            case (ph)
                0: setting = make_setting(16'hFFFF, 16'hFFFF, 16'h7FFF, 16'h7FFF, 16'h8000,
                                          1'b1, 1'b1);
                1: setting = make_setting(16'h0001, 16'h0000, 16'h8000, 16'h8000, 16'h8000,
                                          1'b0, 1'b1);
                default: setting = random_setting();
            endcase
            apply_setting(setting);
            quiet_run  = (ph == RANDOM_PHASES - 1);
            gap_odds   = (ph % 3 == 0) ? 2 : 10;
            stall_odds = (ph % 2 == 0) ? 3 : 12;
            // long receiver hold-off so the block backs up into its input
            if (ph == 2)
                hold_off_req = 1'b1;
            run_random(PHASE_ITEMS);
            s_tvalid <= 1'b0;
        end

        drain();
        $display("ran %0d ticks and %0d target requests under %0d register settings",
                 tick_count, target_count, setting_count);
        $display("%0d needle results compared, %0d mismatches", sb.checked, sb.errors);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("gauge_needle_slew_drive test passed");
        else
            $display("gauge_needle_slew_drive test failed");
        $finish;
    end

endmodule

>>> files.f
hw/rtl/gnsd_pkg.sv
hw/rtl/gnsd_step.sv
hw/rtl/gauge_needle_slew_drive.sv
test/tb.sv
